// ===== rtl/slam_pkg.sv =====
// slam_pkg: shared types, register indexes, codes and fixed-point constants
// for the stereo LFO amplitude modulator. No dependencies.
`default_nettype none

package slam_pkg;

  // Default sizes handed to the top level and to the channel interfaces
  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int PHASE_BITS_DEF   = 24;
  localparam int SINE_ENTRIES_DEF = 1024;

  // Configuration port geometry
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;

  // Modulation factor width, Q31 with headroom for AM overdrive
  localparam int MOD_BITS = 34;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PHASE_STEP,
    REG_MOD_MODE,
    REG_WAVE_SHAPE,
    REG_MOD_DEPTH,
    REG_AM_BIAS,
    REG_RIGHT_OFFSET,
    REG_OUT_GAIN,
    REG_WET_MIX
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_TREMOLO,
    MODE_AM,
    MODE_RING,
    MODE_UNITY
  } mod_mode_t;

  typedef enum logic [1:0] {
    SHAPE_SINE,
    SHAPE_TRIANGLE,
    SHAPE_SQUARE,
    SHAPE_SAW
  } wave_shape_t;

  // Sequencer states; PHASE through SAT run once per channel
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PHASE,
    ST_FOLD,
    ST_SQR,
    ST_C7,
    ST_SUB5,
    ST_T,
    ST_SUB3,
    ST_T2,
    ST_SUB1,
    ST_T3,
    ST_OSC,
    ST_MOD,
    ST_MVAL,
    ST_XLO,
    ST_XHI,
    ST_ACC,
    ST_GAIN,
    ST_WET,
    ST_MIX,
    ST_SAT,
    ST_LOAD
  } state_t;

  // Q1.15 unity, and register reset values
  localparam logic [15:0] ONE_Q15    = 16'h8000;
  localparam logic [15:0] GAIN_RESET = 16'd4096;

  // Odd 7th-order quarter-sine polynomial, Q28 coefficients
  localparam logic [29:0] COEF1 = 30'd421657428;
  localparam logic [29:0] COEF3 = 30'd173399668;
  localparam logic [29:0] COEF5 = 30'd21392319;
  localparam logic [29:0] COEF7 = 30'd1214623;

endpackage

`default_nettype wire

// ===== rtl/slam_if.sv =====
// slam_if: valid/ready channel interfaces for stereo sample requests and
// results. Depends on slam_pkg for the default sample width.
`default_nettype none

interface slam_in_if
  import slam_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          block_end;

  modport source (output valid, output left_in, output right_in, output block_end,
                  input ready);
  modport sink   (input valid, input left_in, input right_in, input block_end,
                  output ready);
endinterface

interface slam_out_if
  import slam_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          block_end_out;

  modport source (output valid, output left_out, output right_out,
                  output block_end_out, input ready);
  modport sink   (input valid, input left_out, input right_out,
                  input block_end_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/stereo_lfo_amplitude_modulator.sv =====
// stereo_lfo_amplitude_modulator: stereo tremolo / AM / ring modulator with
// an LFO (sine by polynomial, triangle, square, saw). Uses slam_pkg, slam_if.
//
//   channel   dir  payload                               handshake
//   sample    in   left_in, right_in, block_end          valid / ready
//   result    out  left_out, right_out, block_end_out    valid / ready
//   cfg       in   cfg_index, cfg_data                   cfg_wr_en
//
// The sequencer runs 20 steps per channel through the single shared
// 18-bit-by-AW multiplier, plus one load step and one idle step; a new
// request is accepted only in the idle step, after the pair is finished.
// A result waiting in the output register stalls only the load step.
// Reset (rst, synchronous) clears the LFO phase and the sequencer and sets
// the configuration registers to their reset values. SINE_ENTRIES is a power of two.
`default_nettype none

module stereo_lfo_amplitude_modulator
  import slam_pkg::*;
#(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int PHASE_BITS   = PHASE_BITS_DEF,
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  slam_in_if.sink                   sample,
  slam_out_if.source                result,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int SINE_LOG = $clog2(SINE_ENTRIES);
  localparam int AW       = (SAMPLE_BITS + 6 > 30) ? SAMPLE_BITS + 6 : 30;
  localparam int BW       = 18;
  localparam int PW       = AW + BW;
  localparam int ACCW     = SAMPLE_BITS + 34;
  localparam int WW       = SAMPLE_BITS + 2;
  localparam int DW       = SAMPLE_BITS + 6;
  localparam int MW       = MOD_BITS;

  localparam logic [PHASE_BITS-1:0] HALF_PHASE = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic [16:0] POS_ONE = 17'h08000;
  localparam logic [16:0] NEG_ONE = 17'h18000;
  localparam logic [16:0] FULL_QUARTER = 17'h10000;
  localparam logic [46:0] SINE_RND = 47'h0000_1000_0000;
  localparam logic signed [MW-1:0] M_UNITY = {{(MW-32){1'b0}}, 1'b1, 31'b0};
  localparam logic signed [ACCW-1:0] ACC_RND = {{(ACCW-31){1'b0}}, 1'b1, 30'b0};
  localparam logic signed [PW-1:0] RND12 = {{(PW-12){1'b0}}, 1'b1, 11'b0};
  localparam logic signed [PW-1:0] RND15 = {{(PW-15){1'b0}}, 1'b1, 14'b0};
  localparam logic signed [PW-1:0] SAT_HI =
    {{(PW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

  // Configuration registers
  logic [23:0]     phase_step;
  mod_mode_t       mod_mode;
  wave_shape_t     wave_shape;
  logic [15:0]     mod_depth;
  logic [15:0]     am_bias;
  logic [23:0]     right_phase_offset;
  logic [15:0]     out_gain;
  logic [15:0]     wet_mix;

  // Control state
  state_t                  state, state_next;
  logic                    ch;
  logic                    res_valid;
  logic [PHASE_BITS-1:0]   lfo_phase;

  // Datapath registers
  logic signed [SAMPLE_BITS-1:0] xl, xr, yl, yr;
  logic                          be;
  logic [PHASE_BITS-1:0]         ph;
  logic [16:0]                   xs, x2;
  logic [29:0]                   tv;
  logic signed [16:0]            g;
  logic signed [MW-1:0]          m;
  logic signed [PW-1:0]          prod;
  logic signed [ACCW-1:0]        acc;
  logic signed [DW-1:0]          dv;
  logic signed [SAMPLE_BITS-1:0] res_left, res_right;
  logic                          res_end;

  // Combinational
  logic signed [SAMPLE_BITS-1:0] x_cur;
  logic signed [AW-1:0]          opa;
  logic signed [BW-1:0]          opb;
  logic signed [PW-1:0]          mul;
  logic [15:0]                   x16;
  logic [16:0]                   xs_next;
  logic [PHASE_BITS-1:0]         tri_d;
  logic [PHASE_BITS+16:0]        tri_w;
  logic [PHASE_BITS+15:0]        saw_w;
  logic [46:0]                   sine_w;
  logic [16:0]                   sine_mag;
  logic signed [16:0]            g_next;
  logic [16:0]                   gpos;
  logic [16:0]                   dinv;
  logic signed [MW-1:0]          m_next;
  logic signed [WW-1:0]          w;
  logic signed [PW-1:0]          rnd12, rnd15, ysum;
  logic signed [SAMPLE_BITS-1:0] y_next;
  logic                          in_take, out_take, load_ok;

  function automatic logic [15:0] clamp_one(input logic [15:0] v);
    clamp_one = (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

  assign in_take  = sample.valid && sample.ready;
  assign out_take = res_valid && result.ready;
  assign load_ok  = !res_valid || result.ready;
  assign x_cur    = ch ? xr : xl;

  // Shared multiplier
  assign mul = opa * opb;

  // Sine position: fold quadrants 1 and 3 back onto the rising quarter
  assign x16 = 16'(16'(ph[PHASE_BITS-3 -: SINE_LOG-2]) << (18 - SINE_LOG));
  assign xs_next = ph[PHASE_BITS-2] ? (FULL_QUARTER - 17'(x16)) : 17'(x16);

  // Oscillator value from the phase and the finished polynomial
  always_comb begin
    tri_d    = ph[PHASE_BITS-1] ? (ph - HALF_PHASE) : (HALF_PHASE - ph);
    tri_w    = {tri_d, 17'b0};
    saw_w    = {ph, 16'b0};
    sine_w   = {1'b0, prod[45:0]} + SINE_RND;
    sine_mag = sine_w[45:29];
    case (wave_shape)
      SHAPE_SINE:     g_next = ph[PHASE_BITS-1] ? (17'd0 - sine_mag) : sine_mag;
      SHAPE_TRIANGLE: g_next = POS_ONE - tri_w[PHASE_BITS+16:PHASE_BITS];
      SHAPE_SQUARE:   g_next = ph[PHASE_BITS-1] ? NEG_ONE : POS_ONE;
      SHAPE_SAW:      g_next = {1'b0, saw_w[PHASE_BITS+15:PHASE_BITS]} - POS_ONE;
      default:        g_next = POS_ONE;
    endcase
  end

  // Modulation factor in Q31
  assign gpos = 17'(g) + POS_ONE;
  assign dinv = POS_ONE - {1'b0, mod_depth};
  always_comb begin
    case (mod_mode)
      MODE_TREMOLO: m_next = (MW'(dinv) << 16) + MW'(prod);
      MODE_AM:      m_next = (MW'(am_bias) << 16) + (MW'(prod) << 1);
      MODE_RING:    m_next = MW'(g) << 16;
      MODE_UNITY:   m_next = M_UNITY;
      default:      m_next = M_UNITY;
    endcase
  end

  // Rounding, blend and saturation
  assign w      = acc[SAMPLE_BITS+32:31];
  assign rnd12  = prod + RND12;
  assign rnd15  = prod + RND15;
  assign ysum   = PW'(x_cur) + (rnd15 >>> 15);
  assign y_next = (ysum > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                  (ysum < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(ysum);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_take) state_next = ST_PHASE;
      ST_PHASE: state_next = ST_FOLD;
      ST_FOLD:  state_next = ST_SQR;
      ST_SQR:   state_next = ST_C7;
      ST_C7:    state_next = ST_SUB5;
      ST_SUB5:  state_next = ST_T;
      ST_T:     state_next = ST_SUB3;
      ST_SUB3:  state_next = ST_T2;
      ST_T2:    state_next = ST_SUB1;
      ST_SUB1:  state_next = ST_T3;
      ST_T3:    state_next = ST_OSC;
      ST_OSC:   state_next = ST_MOD;
      ST_MOD:   state_next = ST_MVAL;
      ST_MVAL:  state_next = ST_XLO;
      ST_XLO:   state_next = ST_XHI;
      ST_XHI:   state_next = ST_ACC;
      ST_ACC:   state_next = ST_GAIN;
      ST_GAIN:  state_next = ST_WET;
      ST_WET:   state_next = ST_MIX;
      ST_MIX:   state_next = ST_SAT;
      ST_SAT:   state_next = ch ? ST_LOAD : ST_PHASE;
      ST_LOAD:  if (load_ok) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Multiplier operand selection per step
  always_comb begin
    opa = '0;
    opb = '0;
    case (state)
      ST_SQR: begin
        opa = AW'(xs);
        opb = BW'(xs);
      end
      ST_C7: begin
        opa = AW'(COEF7);
        opb = BW'(prod[32:16]);
      end
      ST_T, ST_T2: begin
        opa = AW'(tv);
        opb = BW'(x2);
      end
      ST_T3: begin
        opa = AW'(tv);
        opb = BW'(xs);
      end
      ST_MOD: begin
        opa = (mod_mode == MODE_TREMOLO) ? AW'(gpos) : AW'(g);
        opb = BW'(mod_depth);
      end
      ST_XLO: begin
        opa = AW'(x_cur);
        opb = {1'b0, m[16:0]};
      end
      ST_XHI: begin
        opa = AW'(x_cur);
        opb = {m[MW-1], m[MW-1:17]};
      end
      ST_GAIN: begin
        opa = AW'(w);
        opb = BW'(out_gain);
      end
      ST_MIX: begin
        opa = AW'(dv);
        opb = BW'(wet_mix);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Control registers: sequencer, LFO phase, output valid, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      ch                 <= 1'b0;
      res_valid          <= 1'b0;
      lfo_phase          <= '0;
      phase_step         <= '0;
      mod_mode           <= MODE_TREMOLO;
      wave_shape         <= SHAPE_SINE;
      mod_depth          <= ONE_Q15;
      am_bias            <= ONE_Q15;
      right_phase_offset <= '0;
      out_gain           <= GAIN_RESET;
      wet_mix            <= ONE_Q15;
    end else begin
      state <= state_next;
      if (in_take) ch <= 1'b0;
      else if (state == ST_SAT) ch <= ~ch;
      // advance the LFO once both channels have read it
      if (state == ST_SAT && ch) lfo_phase <= lfo_phase + PHASE_BITS'(phase_step);
      if (state == ST_LOAD && load_ok) res_valid <= 1'b1;
      else if (out_take) res_valid <= 1'b0;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PHASE_STEP:   phase_step         <= cfg_data[23:0];
          REG_MOD_MODE:     mod_mode           <= mod_mode_t'(cfg_data[1:0]);
          REG_WAVE_SHAPE:   wave_shape         <= wave_shape_t'(cfg_data[1:0]);
          REG_MOD_DEPTH:    mod_depth          <= clamp_one(cfg_data[15:0]);
          REG_AM_BIAS:      am_bias            <= clamp_one(cfg_data[15:0]);
          REG_RIGHT_OFFSET: right_phase_offset <= cfg_data[23:0];
          REG_OUT_GAIN:     out_gain           <= cfg_data[15:0];
          REG_WET_MIX:      wet_mix            <= clamp_one(cfg_data[15:0]);
          default:          ;
        endcase
      end
    end
  end

  // Datapath registers, stepped by the sequencer
  always_ff @(posedge clk) begin
    prod <= mul;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          xl <= SAMPLE_BITS'(sample.left_in);
          xr <= SAMPLE_BITS'(sample.right_in);
          be <= sample.block_end;
        end
      end
      ST_PHASE: ph <= ch ? (lfo_phase + PHASE_BITS'(right_phase_offset)) : lfo_phase;
      ST_FOLD:  xs <= xs_next;
      ST_C7:    x2 <= prod[32:16];
      ST_SUB5:  tv <= COEF5 - prod[45:16];
      ST_SUB3:  tv <= COEF3 - prod[45:16];
      ST_SUB1:  tv <= COEF1 - prod[45:16];
      ST_OSC:   g  <= g_next;
      ST_MVAL:  m  <= m_next;
      ST_XHI:   acc <= ACCW'(prod);
      ST_ACC:   acc <= acc + (ACCW'(prod) <<< 17) + ACC_RND;
      ST_WET:   dv <= DW'(rnd12 >>> 12) - DW'(x_cur);
      ST_SAT: begin
        if (ch) yr <= y_next;
        else yl <= y_next;
      end
      ST_LOAD: begin
        if (load_ok) begin
          res_left  <= yl;
          res_right <= yr;
          res_end   <= be;
        end
      end
      default: ;
    endcase
  end

  assign sample.ready         = (state == ST_IDLE);
  assign result.valid         = res_valid;
  assign result.left_out      = res_left;
  assign result.right_out     = res_right;
  assign result.block_end_out = res_end;

`ifndef SYNTH
  // a request accepted closes the input until the pair is finished
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !sample.ready)
    else $error("input ready right after an accepted request");

  // the LFO moves only at the end of the right channel
  a_phase_advance: assert property (@(posedge clk) disable iff (rst)
    (!$stable(lfo_phase) && !$past(rst)) |-> $past(state == ST_SAT && ch))
    else $error("LFO phase moved outside the right channel finish");

  // a new result appears only from the load step
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_LOAD))
    else $error("result valid raised outside the load step");

  // clamped Q1.15 registers never exceed one
  a_clamped_regs: assert property (@(posedge clk) disable iff (rst)
    (mod_depth <= ONE_Q15) && (am_bias <= ONE_Q15) && (wet_mix <= ONE_Q15))
    else $error("depth, bias or mix register above one");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench: self-checking bench for the stereo LFO amplitude modulator.
// Predicts every stereo result in a scoreboard class and checks the block against it.
// Depends on slam_pkg, slam_if and the stereo_lfo_amplitude_modulator RTL.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slam_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] left;
    logic signed [SAMPLE_BITS_DEF-1:0] right;
    logic                              tail;
  } stereo_t;

  // Predict each stereo request and hold the results still owed by the block
  class tremolo_scoreboard;
    logic [23:0] step_r, offset_r, phase_r;
    mod_mode_t   mode_r;
    wave_shape_t shape_r;
    logic [15:0] depth_r, bias_r, gain_r, mix_r;
    stereo_t     expected_pairs[$];
    int          checked;
    int          mismatches;

    function new();
      step_r = '0;
      offset_r = '0;
      phase_r = '0;
      mode_r = MODE_TREMOLO;
      shape_r = SHAPE_SINE;
      depth_r = ONE_Q15;
      bias_r = ONE_Q15;
      gain_r = GAIN_RESET;
      mix_r = ONE_Q15;
      checked = 0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [23:0] v);
      case (idx)
        REG_PHASE_STEP:   step_r = v;
        REG_MOD_MODE:     mode_r = mod_mode_t'(v[1:0]);
        REG_WAVE_SHAPE:   shape_r = wave_shape_t'(v[1:0]);
        REG_MOD_DEPTH:    depth_r = v[15:0];
        REG_AM_BIAS:      bias_r = v[15:0];
        REG_RIGHT_OFFSET: offset_r = v;
        REG_OUT_GAIN:     gain_r = v[15:0];
        REG_WET_MIX:      mix_r = v[15:0];
        default: ;
      endcase
    endfunction

    // Q1.15 controls above one behave as one
    function longint unit_clamp(logic [15:0] v);
      return (v > ONE_Q15) ? longint'(32768) : longint'(v);
    endfunction

    // Floor shift after adding half an LSB
    function longint round_sh(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Quarter-wave sine polynomial in Q28, truncating at each step, rounded to Q15
    function longint quarter_sine(longint unsigned x);
      longint unsigned x2, t, t2, t3, s;
      x2 = (x * x) >> 16;
      t = COEF5 - ((x2 * COEF7) >> 16);
      t2 = COEF3 - ((x2 * t) >> 16);
      t3 = COEF1 - ((x2 * t2) >> 16);
      s = (x * t3) >> 16;
      return longint'((s + 4096) >> 13);
    endfunction

    function longint lfo_value(logic [23:0] p);
      longint unsigned pu, half, gap, k, u, x;
      pu = p;
      half = longint'(1) << (PHASE_BITS_DEF - 1);
      case (shape_r)
        SHAPE_TRIANGLE: begin
          gap = (pu >= half) ? pu - half : half - pu;
          return 32768 - longint'((gap << 17) >> PHASE_BITS_DEF);
        end
        SHAPE_SQUARE: return (pu < half) ? longint'(32768) : longint'(-32768);
        SHAPE_SAW:    return longint'((pu << 16) >> PHASE_BITS_DEF) - 32768;
        default: begin
          // Table entry from the top phase bits, folded by quadrant
          k = (pu * SINE_ENTRIES_DEF) >> PHASE_BITS_DEF;
          u = (k * 262144) / SINE_ENTRIES_DEF;
          x = u & 64'hFFFF;
          case (u[17:16])
            2'd0:    return quarter_sine(x);
            2'd1:    return quarter_sine(65536 - x);
            2'd2:    return -quarter_sine(x);
            default: return -quarter_sine(65536 - x);
          endcase
        end
      endcase
    endfunction

    // Modulation factor in Q31
    function longint mod_gain(longint g);
      longint d, b;
      d = unit_clamp(depth_r);
      b = unit_clamp(bias_r);
      case (mode_r)
        MODE_TREMOLO: return (32768 - d) * 65536 + d * (g + 32768);
        MODE_AM:      return b * 65536 + 2 * d * g;
        MODE_RING:    return g * 65536;
        default:      return longint'(1) << 31;
      endcase
    endfunction

    function logic [23:0] channel_sample(logic [23:0] x_raw, longint m);
      longint x, mix, w, wet, y;
      x = longint'($signed(x_raw));
      mix = unit_clamp(mix_r);
      w = round_sh(x * m, 31);
      wet = round_sh(w * longint'(gain_r), 12);
      y = x + round_sh(mix * (wet - x), 15);
      if (y > 8388607) y = 8388607;
      else if (y < -8388608) y = -8388608;
      return y[23:0];
    endfunction

    function void note_request(stereo_t req);
      logic [23:0] left_phase, right_phase;
      stereo_t     want;
      left_phase = phase_r;
      right_phase = phase_r + offset_r;
      want.left = channel_sample(req.left, mod_gain(lfo_value(left_phase)));
      want.right = channel_sample(req.right, mod_gain(lfo_value(right_phase)));
      want.tail = req.tail;
      expected_pairs.push_back(want);
      phase_r = phase_r + step_r;
    endfunction

    function void check_result(stereo_t got);
      stereo_t want;
      if (expected_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: left %0d right %0d end %0b",
                   got.left, got.right, got.tail);
        return;
      end
      want = expected_pairs.pop_front();
      checked++;
      if (got.left !== want.left || got.right !== want.right || got.tail !== want.tail) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: left exp %0d got %0d, right exp %0d got %0d, end exp %0b got %0b",
                   checked, want.left, got.left, want.right, got.right, want.tail, got.tail);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic take_result = 1'b0;
  logic cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  int send_idle = 0;
  int stall_pct = 0;
  int pair_count = 0;
  int setting_count = 0;
  int quiet = 0;

  logic [23:0] corners[6] = '{24'h7FFFFF, 24'h800000, 24'h000000,
                              24'hFFFFFF, 24'h000001, 24'h400000};

  tremolo_scoreboard sb;

  slam_in_if  #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) sample_bus ();
  slam_out_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) result_bus ();

  assign result_bus.ready = take_result;

  stereo_lfo_amplitude_modulator dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_bus),
    .result    (result_bus),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Stall the result side at the current rate
  always @(posedge clk) begin
    take_result <= ($urandom_range(99) >= stall_pct);
  end

  // Record accepted requests and check accepted results
  always @(posedge clk) begin
    if (!rst && sample_bus.valid && sample_bus.ready) begin
      sb.note_request('{sample_bus.left_in, sample_bus.right_in, sample_bus.block_end});
      pair_count++;
    end
    if (!rst && result_bus.valid && result_bus.ready)
      sb.check_result('{result_bus.left_out, result_bus.right_out, result_bus.block_end_out});
  end

  // Abort when no handshake or register write happens for too long
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (sample_bus.valid && sample_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(7))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'($urandom_range(0, 1023)) - 24'd512;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_unit();
    case ($urandom_range(6))
      0:       return 16'h0000;
      1:       return ONE_Q15;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(6))
      0:       return 16'h0000;
      1:       return GAIN_RESET;
      2:       return 16'hFFFF;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(0, 12288));
    endcase
  endfunction

  function automatic logic [23:0] pick_step();
    case ($urandom_range(7))
      0:       return 24'h000000;
      1:       return 24'h800000;
      2:       return 24'hFFFFFF;
      3:       return 24'($urandom);
      default: return 24'($urandom_range(1, 24'h100000));
    endcase
  endfunction

  function automatic logic [23:0] pick_offset();
    case ($urandom_range(5))
      0:       return 24'h000000;
      1:       return 24'h800000;
      2:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic set_idling(int k);
    case (k)
      0:       begin send_idle = 0;  stall_pct = 0;  end
      1:       begin send_idle = 84; stall_pct = 0;  end
      2:       begin send_idle = 0;  stall_pct = 84; end
      default: begin send_idle = 19; stall_pct = 19; end
    endcase
  endtask

  task automatic write_reg(reg_index_t idx, logic [23:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  // Write every register; call only with nothing in flight
  task automatic apply_setting(logic [23:0] step, mod_mode_t mode, wave_shape_t shape,
                               logic [15:0] depth, logic [15:0] bias, logic [23:0] offset,
                               logic [15:0] gain, logic [15:0] mix);
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_MOD_MODE, 24'(mode));
    write_reg(REG_WAVE_SHAPE, 24'(shape));
    write_reg(REG_MOD_DEPTH, 24'(depth));
    write_reg(REG_AM_BIAS, 24'(bias));
    write_reg(REG_RIGHT_OFFSET, offset);
    write_reg(REG_OUT_GAIN, 24'(gain));
    write_reg(REG_WET_MIX, 24'(mix));
    cfg_wr_en <= 1'b0;
    setting_count++;
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_drained();
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pairs.size() != 0) @(posedge clk);
  endtask

  task automatic send_request(logic [23:0] l, logic [23:0] r, logic be);
    if ($urandom_range(99) < send_idle) begin
      sample_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.left_in <= l;
    sample_bus.right_in <= r;
    sample_bus.block_end <= be;
    do @(posedge clk); while (!sample_bus.ready);
  endtask

  task automatic send_batch(int n, bit corner, bit hold_mid);
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) wait_drained();
      if (corner)
        send_request(corners[i % 6], corners[(i + 3) % 6], i[0]);
      else
        send_request(rand_sample(), rand_sample(), $urandom_range(3) == 0);
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_PHASE_STEP;
    cfg_data <= '0;
    sample_bus.valid <= 1'b0;
    sample_bus.left_in <= '0;
    sample_bus.right_in <= '0;
    sample_bus.block_end <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, then overdrive, wrap, zero gain and each mode/shape
    set_idling(0);
    send_batch(6, 1, 0);
    apply_setting(24'h400000, MODE_AM, SHAPE_SQUARE, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
                  16'hFFFF, 16'hFFFF);
    send_batch(4, 1, 0);
    apply_setting(24'hFFFFFF, MODE_RING, SHAPE_SAW, ONE_Q15, 16'h0000, 24'h800000,
                  16'h0000, 16'h4000);
    send_batch(4, 1, 0);
    apply_setting(24'h155555, MODE_TREMOLO, SHAPE_TRIANGLE, 16'h0000, ONE_Q15, 24'h000000,
                  GAIN_RESET, 16'h0000);
    send_batch(4, 1, 0);
    apply_setting(24'h0B0000, MODE_UNITY, SHAPE_SINE, ONE_Q15, ONE_Q15, 24'h400000,
                  16'd8192, ONE_Q15);
    send_batch(4, 1, 0);

    // Random: every mode/shape pair, each idle pattern, random register values
    for (logic [4:0] p = 0; p < 16; p++) begin
      set_idling((p + p / 4) % 4);
      apply_setting(pick_step(), mod_mode_t'(p[1:0]), wave_shape_t'(p[3:2]), pick_unit(),
                    pick_unit(), pick_offset(), pick_gain(), pick_unit());
      send_batch(96, 0, p % 3 == 1);
    end

    // Let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run: %0d stereo requests over %0d register settings, all modes and shapes,",
             pair_count, setting_count);
    $display("run: mixed sender gaps and result stalls; %0d results checked, %0d mismatches",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_pairs.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
